// ===== hdl/partition_request_splitter_macros.svh =====
// Assertion macros for the partition request splitter.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef PARTITION_REQUEST_SPLITTER_MACROS_SVH
`define PARTITION_REQUEST_SPLITTER_MACROS_SVH

// Check that a consequent holds in the same cycle as its trigger.
`define PRS_ASSERT_SAME(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("partition_request_splitter: same-cycle check failed");

// Check that a consequent holds in the cycle after its trigger.
`define PRS_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("partition_request_splitter: next-cycle check failed");

`endif

// ===== hdl/prs_pkg.sv =====
// Package for the partition request splitter: widths, payload types,
// sequencer states and shared adder types. No dependencies.
package prs_pkg;

    localparam int MAX_BATCH_SECTORS = 8;
    localparam int MAX_REQUEST_BYTES = 131072;
    localparam int MIN_SHIFT         = 9;
    localparam int MAX_SHIFT         = 12;

    localparam int OFFSET_W = 32;
    localparam int BASE_W   = 32;
    localparam int LENGTH_W = 48;
    localparam int SHIFT_W  = 4;
    localparam int COUNT_W  = 18;
    localparam int LBA_W    = 49;
    localparam int BATCH_W  = 4;
    localparam int SKIP_W   = 12;
    localparam int POS_W    = 17;
    localparam int COPY_W   = 16;
    localparam int TOT_W    = 18;
    localparam int SECT_W   =
        $clog2(((MAX_REQUEST_BYTES + 2 * (1 << MAX_SHIFT)) >> MIN_SHIFT) + 1);

    typedef struct packed {
        logic                operation;
        logic [OFFSET_W-1:0] byte_offset;
        logic [COUNT_W-1:0]  byte_count;
        logic [BASE_W-1:0]   partition_base;
        logic [LENGTH_W-1:0] partition_length;
        logic [SHIFT_W-1:0]  sector_shift;
    } req_t;

    typedef struct packed {
        logic               has_command;
        logic               read_first;
        logic [LBA_W-1:0]   command_lba;
        logic [BATCH_W-1:0] command_sectors;
        logic [SKIP_W-1:0]  buffer_skip;
        logic [POS_W-1:0]   caller_position;
        logic [COPY_W-1:0]  copy_bytes;
        logic [TOT_W-1:0]   total_bytes;
        logic               last;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LBA,
        ST_END,
        ST_SUM,
        ST_ROUND,
        ST_AVAIL,
        ST_CLIP,
        ST_TRIM,
        ST_LIMIT,
        ST_BATCH,
        ST_EMPTY
    } state_t;

    typedef struct packed {
        logic [LBA_W-1:0] a;
        logic [LBA_W-1:0] b;
        logic             sub;
    } alu_req_t;

    typedef struct packed {
        logic [LBA_W-1:0] result;
        logic             carry;
    } alu_rsp_t;

endpackage

// ===== hdl/prs_stream_if.sv =====
// Valid/ready channel carrying one payload per transaction.
// Payload type comes from prs_pkg at instantiation.
interface prs_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/partition_request_splitter.sv =====
// Top level of the partition request splitter: sequencer, datapath registers
// and result register. Depends on prs_pkg, prs_stream_if, prs_alu and the macro header.
//
// Usage:
//   req  (sink)   one read or write request per transaction, prs_pkg::req_t.
//   cmd  (source) sector commands, prs_pkg::cmd_t, one per batch of up to eight
//                 sectors; the final one of a request has last set. A request
//                 that lies past the partition end or moves no bytes gives one
//                 result with has_command 0 and last 1.
// Timing:
//   req.ready is high only while the sequencer is idle. After acceptance the
//   shared 49-bit adder runs six setup steps (eight for a write clipped at
//   the partition end), then one result per cycle while cmd.ready is high,
//   N <= 33 results. An empty request runs five setup steps before its
//   single result.
// Reset:
//   rst_n low clears the sequencer to idle and drops cmd.valid.
// Stall:
//   While cmd.ready is low the result register holds and the sequencer waits
//   before issuing; a new request is still taken once the last result is registered.
`include "partition_request_splitter_macros.svh"

module partition_request_splitter (
    input  logic          clk,
    input  logic          rst_n,
    prs_stream_if.sink    req,
    prs_stream_if.source  cmd
);

    prs_pkg::state_t state_reg, state_next;

    logic                          cmd_valid_reg, cmd_valid_next;
    prs_pkg::cmd_t                 cmd_reg, cmd_next;

    logic                          write_reg, write_next;
    logic [prs_pkg::SHIFT_W-1:0]   shift_reg, shift_next;
    logic [prs_pkg::OFFSET_W-1:0]  offset_reg, offset_next;
    logic [prs_pkg::BASE_W-1:0]    base_reg, base_next;
    logic [prs_pkg::LENGTH_W-1:0]  length_reg, length_next;
    logic [prs_pkg::SKIP_W-1:0]    skip_reg, skip_next;
    logic [prs_pkg::LBA_W-1:0]     lba_reg, lba_next;
    logic [prs_pkg::LBA_W-1:0]     end_reg, end_next;
    logic [prs_pkg::TOT_W-1:0]     tmp_reg, tmp_next;
    logic [prs_pkg::SECT_W-1:0]    sectors_reg, sectors_next;
    logic [prs_pkg::TOT_W-1:0]     remaining_reg, remaining_next;
    logic [prs_pkg::TOT_W-1:0]     total_reg, total_next;

    prs_pkg::alu_req_t             alu_req;
    prs_pkg::alu_rsp_t             alu_rsp;

    logic                          in_fire;
    logic                          issue;
    logic                          empty;
    logic [prs_pkg::SKIP_W-1:0]    mask;
    logic [prs_pkg::SHIFT_W-1:0]   shift_clamped;
    logic [prs_pkg::TOT_W-1:0]     size_clamped;
    logic [prs_pkg::BATCH_W-1:0]   batch;
    logic [prs_pkg::COPY_W-1:0]    span;
    logic [prs_pkg::COPY_W-1:0]    span_skip;
    logic                          borrow;
    logic [prs_pkg::COPY_W-1:0]    copy;
    logic [prs_pkg::TOT_W-1:0]     rem_after;
    logic [prs_pkg::SECT_W-1:0]    sectors_after;
    logic [prs_pkg::TOT_W-1:0]     total_after;
    logic                          batch_last;
    logic                          read_first;

    prs_alu u_alu (
        .op  (alu_req),
        .res (alu_rsp)
    );

    assign in_fire   = req.valid && req.ready;
    assign cmd.valid = cmd_valid_reg;
    assign cmd.payload = cmd_reg;

    always_comb
    begin
        mask = ~(prs_pkg::SKIP_W'({prs_pkg::SKIP_W{1'b1}}) << shift_reg);

        if (req.payload.sector_shift < prs_pkg::SHIFT_W'(prs_pkg::MIN_SHIFT))
        begin
            shift_clamped = prs_pkg::SHIFT_W'(prs_pkg::MIN_SHIFT);
        end
        else if (req.payload.sector_shift > prs_pkg::SHIFT_W'(prs_pkg::MAX_SHIFT))
        begin
            shift_clamped = prs_pkg::SHIFT_W'(prs_pkg::MAX_SHIFT);
        end
        else
        begin
            shift_clamped = req.payload.sector_shift;
        end

        if (req.payload.byte_count > prs_pkg::COUNT_W'(prs_pkg::MAX_REQUEST_BYTES))
        begin
            size_clamped = prs_pkg::TOT_W'(prs_pkg::MAX_REQUEST_BYTES);
        end
        else
        begin
            size_clamped = prs_pkg::TOT_W'(req.payload.byte_count);
        end

        if (sectors_reg > prs_pkg::SECT_W'(prs_pkg::MAX_BATCH_SECTORS))
        begin
            batch = prs_pkg::BATCH_W'(prs_pkg::MAX_BATCH_SECTORS);
        end
        else
        begin
            batch = sectors_reg[prs_pkg::BATCH_W-1:0];
        end
        span          = prs_pkg::COPY_W'(batch) << shift_reg;
        span_skip     = span - prs_pkg::COPY_W'(skip_reg);
        borrow        = alu_rsp.carry;
        copy          = borrow ? remaining_reg[prs_pkg::COPY_W-1:0] : span_skip;
        rem_after     = borrow ? '0 : alu_rsp.result[prs_pkg::TOT_W-1:0];
        sectors_after = sectors_reg - prs_pkg::SECT_W'(batch);
        total_after   = total_reg + prs_pkg::TOT_W'(copy);
        batch_last    = borrow || (rem_after == '0) || (sectors_after == '0);
        read_first    = write_reg && ((skip_reg != '0) || borrow);

        empty = alu_rsp.carry || (alu_rsp.result == '0) || (remaining_reg == '0);
    end

    // Sequencer outputs: handshake and shared adder operands.
    always_comb
    begin
        req.ready   = (state_reg == prs_pkg::ST_IDLE);
        issue       = ((state_reg == prs_pkg::ST_BATCH) || (state_reg == prs_pkg::ST_EMPTY))
                      && (!cmd_valid_reg || cmd.ready);
        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.sub = 1'b0;
        case (state_reg)
            prs_pkg::ST_LBA:
            begin
                alu_req.a = prs_pkg::LBA_W'(base_reg);
                alu_req.b = prs_pkg::LBA_W'(offset_reg >> shift_reg);
            end
            prs_pkg::ST_END:
            begin
                alu_req.a = prs_pkg::LBA_W'(base_reg);
                alu_req.b = prs_pkg::LBA_W'(length_reg);
            end
            prs_pkg::ST_SUM:
            begin
                alu_req.a = prs_pkg::LBA_W'(remaining_reg);
                alu_req.b = prs_pkg::LBA_W'(skip_reg);
            end
            prs_pkg::ST_ROUND:
            begin
                alu_req.a = prs_pkg::LBA_W'(tmp_reg);
                alu_req.b = prs_pkg::LBA_W'(mask);
            end
            prs_pkg::ST_AVAIL:
            begin
                alu_req.a   = end_reg;
                alu_req.b   = lba_reg;
                alu_req.sub = 1'b1;
            end
            prs_pkg::ST_CLIP:
            begin
                alu_req.a   = end_reg;
                alu_req.b   = prs_pkg::LBA_W'(sectors_reg);
                alu_req.sub = 1'b1;
            end
            prs_pkg::ST_TRIM:
            begin
                alu_req.a   = prs_pkg::LBA_W'(sectors_reg) << shift_reg;
                alu_req.b   = prs_pkg::LBA_W'(skip_reg);
                alu_req.sub = 1'b1;
            end
            prs_pkg::ST_LIMIT:
            begin
                alu_req.a   = prs_pkg::LBA_W'(remaining_reg);
                alu_req.b   = prs_pkg::LBA_W'(tmp_reg);
                alu_req.sub = 1'b1;
            end
            prs_pkg::ST_BATCH:
            begin
                alu_req.a   = prs_pkg::LBA_W'(remaining_reg);
                alu_req.b   = prs_pkg::LBA_W'(span_skip);
                alu_req.sub = 1'b1;
            end
            default:
            begin
                alu_req.sub = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            prs_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = prs_pkg::ST_LBA;
                end
            end
            prs_pkg::ST_LBA:   state_next = prs_pkg::ST_END;
            prs_pkg::ST_END:   state_next = prs_pkg::ST_SUM;
            prs_pkg::ST_SUM:   state_next = prs_pkg::ST_ROUND;
            prs_pkg::ST_ROUND: state_next = prs_pkg::ST_AVAIL;
            prs_pkg::ST_AVAIL:
            begin
                state_next = empty ? prs_pkg::ST_EMPTY : prs_pkg::ST_CLIP;
            end
            prs_pkg::ST_CLIP:
            begin
                if (alu_rsp.carry && write_reg)
                begin
                    state_next = prs_pkg::ST_TRIM;
                end
                else
                begin
                    state_next = prs_pkg::ST_BATCH;
                end
            end
            prs_pkg::ST_TRIM:  state_next = prs_pkg::ST_LIMIT;
            prs_pkg::ST_LIMIT: state_next = prs_pkg::ST_BATCH;
            prs_pkg::ST_BATCH:
            begin
                if (issue && batch_last)
                begin
                    state_next = prs_pkg::ST_IDLE;
                end
            end
            prs_pkg::ST_EMPTY:
            begin
                if (issue)
                begin
                    state_next = prs_pkg::ST_IDLE;
                end
            end
            default:           state_next = prs_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        write_next     = write_reg;
        shift_next     = shift_reg;
        offset_next    = offset_reg;
        base_next      = base_reg;
        length_next    = length_reg;
        skip_next      = skip_reg;
        lba_next       = lba_reg;
        end_next       = end_reg;
        tmp_next       = tmp_reg;
        sectors_next   = sectors_reg;
        remaining_next = remaining_reg;
        total_next     = total_reg;
        cmd_next       = cmd_reg;
        cmd_valid_next = cmd_valid_reg && !cmd.ready;

        case (state_reg)
            prs_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    write_next     = req.payload.operation;
                    shift_next     = shift_clamped;
                    offset_next    = req.payload.byte_offset;
                    base_next      = req.payload.partition_base;
                    length_next    = req.payload.partition_length;
                    remaining_next = size_clamped;
                    total_next     = '0;
                end
            end
            prs_pkg::ST_LBA:
            begin
                lba_next  = alu_rsp.result;
                skip_next = offset_reg[prs_pkg::SKIP_W-1:0] & mask;
            end
            prs_pkg::ST_END:
            begin
                end_next = alu_rsp.result;
            end
            prs_pkg::ST_SUM:
            begin
                tmp_next = alu_rsp.result[prs_pkg::TOT_W-1:0];
            end
            prs_pkg::ST_ROUND:
            begin
                sectors_next = prs_pkg::SECT_W'(alu_rsp.result[prs_pkg::TOT_W-1:0] >> shift_reg);
            end
            prs_pkg::ST_AVAIL:
            begin
                end_next = alu_rsp.result;
            end
            prs_pkg::ST_CLIP:
            begin
                if (alu_rsp.carry)
                begin
                    sectors_next = end_reg[prs_pkg::SECT_W-1:0];
                end
            end
            prs_pkg::ST_TRIM:
            begin
                tmp_next = alu_rsp.result[prs_pkg::TOT_W-1:0];
            end
            prs_pkg::ST_LIMIT:
            begin
                if (!alu_rsp.carry)
                begin
                    remaining_next = tmp_reg;
                end
            end
            prs_pkg::ST_BATCH:
            begin
                if (issue)
                begin
                    cmd_valid_next          = 1'b1;
                    cmd_next.has_command     = 1'b1;
                    cmd_next.read_first      = read_first;
                    cmd_next.command_lba     = lba_reg;
                    cmd_next.command_sectors = batch;
                    cmd_next.buffer_skip     = skip_reg;
                    cmd_next.caller_position = total_reg[prs_pkg::POS_W-1:0];
                    cmd_next.copy_bytes      = copy;
                    cmd_next.total_bytes     = total_after;
                    cmd_next.last            = batch_last;
                    lba_next                 = lba_reg + prs_pkg::LBA_W'(batch);
                    skip_next                = '0;
                    total_next               = total_after;
                    remaining_next           = rem_after;
                    sectors_next             = sectors_after;
                end
            end
            prs_pkg::ST_EMPTY:
            begin
                if (issue)
                begin
                    cmd_valid_next = 1'b1;
                    cmd_next       = '0;
                    cmd_next.last  = 1'b1;
                end
            end
            default:
            begin
                cmd_valid_next = cmd_valid_reg && !cmd.ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prs_pkg::ST_IDLE;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        write_reg     <= write_next;
        shift_reg     <= shift_next;
        offset_reg    <= offset_next;
        base_reg      <= base_next;
        length_reg    <= length_next;
        skip_reg      <= skip_next;
        lba_reg       <= lba_next;
        end_reg       <= end_next;
        tmp_reg       <= tmp_next;
        sectors_reg   <= sectors_next;
        remaining_reg <= remaining_next;
        total_reg     <= total_next;
    end

    `PRS_ASSERT_NEXT(a_accept_starts_setup, in_fire, state_reg == prs_pkg::ST_LBA)
    `PRS_ASSERT_SAME(a_empty_is_last, cmd_valid_reg && !cmd_reg.has_command, cmd_reg.last)
    `PRS_ASSERT_SAME(a_command_moves_bytes, cmd_valid_reg && cmd_reg.has_command,
        cmd_reg.copy_bytes != '0)

endmodule

// ===== hdl/prs_alu.sv =====
// Shared add/subtract unit of the splitter sequencer.
// Depends on prs_pkg for operand and result types.
module prs_alu (
    input  prs_pkg::alu_req_t op,
    output prs_pkg::alu_rsp_t res
);

    logic [prs_pkg::LBA_W:0] sum;

    always_comb
    begin
        if (op.sub)
        begin
            sum = {1'b0, op.a} - {1'b0, op.b};
        end
        else
        begin
            sum = {1'b0, op.a} + {1'b0, op.b};
        end
        res.carry  = sum[prs_pkg::LBA_W];
        res.result = sum[prs_pkg::LBA_W-1:0];
    end

endmodule
